### rtl/core/sts_pkg.sv
// Shared types, codes and arithmetic helpers for the simplex tableau solver.
package sts_pkg;

    localparam int VALUE_BITS = 48;
    localparam int ROWS       = 8;
    localparam int COLS       = 16;
    localparam int ROW_W      = 3;
    localparam int COL_W      = 4;
    localparam int ADDR_W     = ROW_W + COL_W;
    localparam int DEPTH      = ROWS * COLS;

    typedef logic signed [VALUE_BITS-1:0] t_value;

    localparam t_value VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam t_value VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    // command codes (tuser)
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_SOLVE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // solve status codes
    localparam logic [1:0] ST_OPTIMAL   = 2'd0;
    localparam logic [1:0] ST_UNBOUNDED = 2'd1;
    localparam logic [1:0] ST_LIMIT     = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_ROWS  = 2'd0;
    localparam logic [1:0] CFG_COLS  = 2'd1;
    localparam logic [1:0] CFG_LIMIT = 2'd2;

    // tableau memory access for one cycle
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_value            wdata;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
    } t_mem_req;

    function automatic logic [VALUE_BITS-1:0] mag(input t_value v);
        mag = v[VALUE_BITS-1] ? VALUE_BITS'(-v) : VALUE_BITS'(v);
    endfunction

    // saturating a - b
    function automatic t_value sub_sat(input t_value a, input t_value b);
        logic signed [VALUE_BITS:0] d;
        d = {a[VALUE_BITS-1], a} - {b[VALUE_BITS-1], b};
        if (d[VALUE_BITS] != d[VALUE_BITS-1]) begin
            sub_sat = d[VALUE_BITS] ? VMIN : VMAX;
        end else begin
            sub_sat = d[VALUE_BITS-1:0];
        end
    endfunction

endpackage

### rtl/core/simplex_tableau_solver.sv
// Simplex tableau store with built-in pivoting solver (top level).
//
// Input stream: tuser carries the command (write entry, solve, read entry), tdata
// the row, column and Q32.16 entry. A write is absorbed in the idle state and gives
// no word out. A read passes the read-data and deliver states before output valid rises. A solve
// gives one word (status, pivot count, zero value) when the method ends.
// Each pivot scans the objective row, divides the right-hand side by every
// constraint row's positive pivot-column entry (one division each), scales
// the pivot row entry by entry through the serial divider, and eliminates the
// pivot column from every other row in use through the serial multiplier.
// Input ready is high only while the sequencer is idle; a finished result
// waits in the deliver state until the output register is free, so a stalled
// receiver holds off the next input word until the result has moved there.
// Configuration writes are accepted every cycle and are meant for idle time.
// Synchronous active-low reset zeroes the tableau (per-entry valid bits),
// status and pivot count, and loads rows 5, columns 9, pivot limit 64.
module simplex_tableau_solver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [55:0] i_s_axis_tdata,   // row_index[2:0], column_index[6:3], entry_value[54:7]
    input  logic [1:0]  i_s_axis_tuser,   // cmd[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // read_value[47:0], solve_status[49:48], pivots_done[57:50]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_RD_DATA = 14'b00000000000010,
        S_DELIVER = 14'b00000000000100,
        S_COL_RD  = 14'b00000000001000,
        S_COL_CHK = 14'b00000000010000,
        S_ROW_RD  = 14'b00000000100000,
        S_ROW_CHK = 14'b00000001000000,
        S_ROW_DIV = 14'b00000010000000,
        S_PR_RD   = 14'b00000100000000,
        S_PR_GO   = 14'b00001000000000,
        S_PR_DIV  = 14'b00010000000000,
        S_EL_RD   = 14'b00100000000000,
        S_EL_GO   = 14'b01000000000000,
        S_EL_MUL  = 14'b10000000000000
    } t_state;

    t_state r_state;

    // configuration
    logic [3:0] r_rows;
    logic [4:0] r_cols;
    logic [7:0] r_limit;

    // solve results
    logic [1:0] r_status;
    logic [7:0] r_count;

    // output register and holding stage
    logic            r_out_valid;
    sts_pkg::t_value r_out_value;
    logic [1:0]      r_out_status;
    logic [7:0]      r_out_count;
    sts_pkg::t_value r_res_value;

    // sequencer working state
    logic [sts_pkg::ROW_W-1:0] r_r;
    logic [sts_pkg::COL_W-1:0] r_c;
    logic [sts_pkg::ROW_W-1:0] r_pr;
    logic [sts_pkg::COL_W-1:0] r_pc;
    logic                      r_have_col;
    logic                      r_have_row;
    sts_pkg::t_value           r_best;
    sts_pkg::t_value           r_opnd;
    sts_pkg::t_value           r_pv;
    sts_pkg::t_value           r_copy [0:sts_pkg::ROWS-1];

    logic [3:0]                nr;
    logic [4:0]                nc;
    logic [sts_pkg::ROW_W-1:0] obj;
    logic [sts_pkg::COL_W-1:0] rhs;

    logic                      in_acc;
    logic [1:0]                in_cmd;
    logic [sts_pkg::ROW_W-1:0] in_row;
    logic [sts_pkg::COL_W-1:0] in_col;
    sts_pkg::t_value           in_val;

    sts_pkg::t_mem_req mem_req;
    sts_pkg::t_value   rdata_a;
    sts_pkg::t_value   rdata_b;

    logic            div_start;
    sts_pkg::t_value div_num;
    sts_pkg::t_value div_den;
    logic            div_done;
    sts_pkg::t_value div_q;

    logic            mul_start;
    logic            mul_done;
    sts_pkg::t_value mul_p;

    logic            col_take;
    logic            have_col_now;
    logic            e_pos;
    logic            ratio_take;
    logic [3:0]      r_nxt1;
    logic [3:0]      r_nxt2;

    assign in_cmd = i_s_axis_tuser;
    assign in_row = i_s_axis_tdata[2:0];
    assign in_col = i_s_axis_tdata[6:3];
    assign in_val = i_s_axis_tdata[54:7];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b0, r_out_count, r_out_status, r_out_value};

    // register values clamped to the store
    always_comb begin
        if (r_rows < 4'd2) begin
            nr = 4'd2;
        end else if (r_rows > 4'(sts_pkg::ROWS)) begin
            nr = 4'(sts_pkg::ROWS);
        end else begin
            nr = r_rows;
        end
        if (r_cols < 5'd2) begin
            nc = 5'd2;
        end else if (r_cols > 5'(sts_pkg::COLS)) begin
            nc = 5'(sts_pkg::COLS);
        end else begin
            nc = r_cols;
        end
        obj = sts_pkg::ROW_W'(nr - 4'd1);
        rhs = sts_pkg::COL_W'(nc - 5'd1);
    end

    // pivot selection helpers
    assign col_take     = rdata_a[sts_pkg::VALUE_BITS-1] && (!r_have_col || rdata_a < r_best);
    assign have_col_now = r_have_col || col_take;
    assign e_pos        = !rdata_a[sts_pkg::VALUE_BITS-1] && (rdata_a != '0);
    assign ratio_take   = !r_have_row || div_q < r_best;
    assign r_nxt1       = {1'b0, r_r} + 4'd1;
    assign r_nxt2       = (r_nxt1 == {1'b0, r_pr}) ? r_nxt1 + 4'd1 : r_nxt1;

    // memory access per state
    always_comb begin
        mem_req         = '0;
        mem_req.raddr_a = {in_row, in_col};
        mem_req.raddr_b = {r_r, rhs};
        case (r_state)
            S_IDLE: begin
                if (in_acc && in_cmd == sts_pkg::CMD_WRITE) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = {in_row, in_col};
                    mem_req.wdata = in_val;
                end
            end
            S_COL_RD: mem_req.raddr_a = {obj, r_c};
            S_ROW_RD: begin
                mem_req.raddr_a = {r_r, r_pc};
                mem_req.raddr_b = {r_r, rhs};
            end
            S_PR_RD: mem_req.raddr_a = {r_pr, r_c};
            S_PR_DIV: begin
                mem_req.we    = div_done;
                mem_req.waddr = {r_pr, r_c};
                mem_req.wdata = div_q;
            end
            S_EL_RD: begin
                mem_req.raddr_a = {r_r, r_c};
                mem_req.raddr_b = {r_pr, r_c};
            end
            S_EL_MUL: begin
                mem_req.we    = mul_done;
                mem_req.waddr = {r_r, r_c};
                mem_req.wdata = sts_pkg::sub_sat(r_opnd, mul_p);
            end
            default: ;
        endcase
    end

    // ratio division (rhs / entry) or pivot-row scaling (entry / pivot)
    assign div_start = (r_state == S_ROW_CHK && r_r < obj && e_pos) || (r_state == S_PR_GO);
    assign div_num   = (r_state == S_ROW_CHK) ? rdata_b : rdata_a;
    assign div_den   = (r_state == S_ROW_CHK) ? rdata_a : r_pv;
    assign mul_start = (r_state == S_EL_GO);

    sts_tab_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    sts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    sts_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (r_copy[r_r]),
        .i_b     (rdata_b),
        .o_done  (mul_done),
        .o_prod  (mul_p)
    );

    // copy of the pivot column, taken during the ratio pass
    always_ff @(posedge i_clk) begin
        if (r_state == S_ROW_CHK) begin
            r_copy[r_r] <= rdata_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rows      <= 4'd5;
            r_cols      <= 5'd9;
            r_limit     <= 8'd64;
            r_status    <= sts_pkg::ST_OPTIMAL;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_have_col  <= 1'b0;
            r_have_row  <= 1'b0;
            r_r         <= '0;
            r_c         <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    sts_pkg::CFG_ROWS:  r_rows  <= i_cfg_data[3:0];
                    sts_pkg::CFG_COLS:  r_cols  <= i_cfg_data[4:0];
                    sts_pkg::CFG_LIMIT: r_limit <= i_cfg_data;
                    default: ;
                endcase
            end

            // the deliver state reloads the output register itself
            if (r_out_valid && i_m_axis_tready && r_state != S_DELIVER) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (in_cmd)
                            sts_pkg::CMD_SOLVE: begin
                                r_count    <= '0;
                                r_c        <= '0;
                                r_have_col <= 1'b0;
                                r_state    <= S_COL_RD;
                            end
                            sts_pkg::CMD_READ: r_state <= S_RD_DATA;
                            default: ;
                        endcase
                    end
                end
                S_RD_DATA: begin
                    r_res_value <= rdata_a;
                    r_state     <= S_DELIVER;
                end
                S_DELIVER: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid  <= 1'b1;
                        r_out_value  <= r_res_value;
                        r_out_status <= r_status;
                        r_out_count  <= r_count;
                        r_state      <= S_IDLE;
                    end
                end
                S_COL_RD: r_state <= S_COL_CHK;
                S_COL_CHK: begin
                    if (col_take) begin
                        r_best     <= rdata_a;
                        r_pc       <= r_c;
                        r_have_col <= 1'b1;
                    end
                    if (r_c == rhs - 4'd1) begin
                        if (!have_col_now) begin
                            r_status    <= sts_pkg::ST_OPTIMAL;
                            r_res_value <= '0;
                            r_state     <= S_DELIVER;
                        end else if (r_count >= r_limit) begin
                            r_status    <= sts_pkg::ST_LIMIT;
                            r_res_value <= '0;
                            r_state     <= S_DELIVER;
                        end else begin
                            r_r        <= '0;
                            r_have_row <= 1'b0;
                            r_state    <= S_ROW_RD;
                        end
                    end else begin
                        r_c     <= r_c + 4'd1;
                        r_state <= S_COL_RD;
                    end
                end
                S_ROW_RD: r_state <= S_ROW_CHK;
                S_ROW_CHK: begin
                    if (r_r < obj && e_pos) begin
                        r_opnd  <= rdata_a;
                        r_state <= S_ROW_DIV;
                    end else if (r_r == obj) begin
                        if (!r_have_row) begin
                            r_status    <= sts_pkg::ST_UNBOUNDED;
                            r_res_value <= '0;
                            r_state     <= S_DELIVER;
                        end else begin
                            r_c     <= '0;
                            r_state <= S_PR_RD;
                        end
                    end else begin
                        r_r     <= r_r + 3'd1;
                        r_state <= S_ROW_RD;
                    end
                end
                S_ROW_DIV: begin
                    if (div_done) begin
                        if (ratio_take) begin
                            r_best     <= div_q;
                            r_pr       <= r_r;
                            r_pv       <= r_opnd;
                            r_have_row <= 1'b1;
                        end
                        r_r     <= r_r + 3'd1;
                        r_state <= S_ROW_RD;
                    end
                end
                S_PR_RD: r_state <= S_PR_GO;
                S_PR_GO: r_state <= S_PR_DIV;
                S_PR_DIV: begin
                    if (div_done) begin
                        if (r_c == rhs) begin
                            r_c     <= '0;
                            r_r     <= (r_pr == '0) ? 3'd1 : 3'd0;
                            r_state <= S_EL_RD;
                        end else begin
                            r_c     <= r_c + 4'd1;
                            r_state <= S_PR_RD;
                        end
                    end
                end
                S_EL_RD: r_state <= S_EL_GO;
                S_EL_GO: begin
                    r_opnd  <= rdata_a;
                    r_state <= S_EL_MUL;
                end
                S_EL_MUL: begin
                    if (mul_done) begin
                        if (r_c == rhs) begin
                            r_c <= '0;
                            if (r_nxt2 >= nr) begin
                                r_count    <= r_count + 8'd1;
                                r_have_col <= 1'b0;
                                r_state    <= S_COL_RD;
                            end else begin
                                r_r     <= r_nxt2[2:0];
                                r_state <= S_EL_RD;
                            end
                        end else begin
                            r_c     <= r_c + 4'd1;
                            r_state <= S_EL_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.we |-> (r_state == S_IDLE || r_state == S_PR_DIV || r_state == S_EL_MUL))
        else $error("tableau written outside a write phase");

    a_limit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DELIVER && $past(r_state) == S_COL_CHK && r_status == sts_pkg::ST_LIMIT)
        |-> r_count == r_limit)
        else $error("pivot limit reported with wrong count");

    a_pivot_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PR_RD) |-> (r_pr < obj && r_have_row))
        else $error("pivot row outside constraint rows");
`endif

endmodule

### rtl/core/sts_tab_mem.sv
// Tableau store: one write port, two registered read ports, per-entry valid bits.
module sts_tab_mem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sts_pkg::t_mem_req i_req,
    output sts_pkg::t_value   o_rdata_a,
    output sts_pkg::t_value   o_rdata_b
);

    sts_pkg::t_value            r_mem [0:sts_pkg::DEPTH-1];
    logic [sts_pkg::DEPTH-1:0]  r_valid;
    sts_pkg::t_value            r_da;
    sts_pkg::t_value            r_db;
    logic                       r_va;
    logic                       r_vb;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_da <= r_mem[i_req.raddr_a];
        r_db <= r_mem[i_req.raddr_b];
    end

    // entries never written since reset read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_va    <= 1'b0;
            r_vb    <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_valid[i_req.waddr] <= 1'b1;
            end
            r_va <= r_valid[i_req.raddr_a];
            r_vb <= r_valid[i_req.raddr_b];
        end
    end

    assign o_rdata_a = r_va ? r_da : '0;
    assign o_rdata_b = r_vb ? r_db : '0;

endmodule

### rtl/core/sts_div.sv
// Radix-2 restoring divider: (num * 2^16) / den, truncated, saturated.
module sts_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  sts_pkg::t_value i_num,
    input  sts_pkg::t_value i_den,
    output logic            o_done,
    output sts_pkg::t_value o_quot
);

    localparam int VB = sts_pkg::VALUE_BITS;
    localparam int WB = VB + 16;

    logic          r_busy;
    logic          r_done;
    logic [6:0]    r_cnt;
    logic [WB-1:0] r_work;
    logic [VB-1:0] r_rem;
    logic [VB-1:0] r_den;
    logic          r_neg;
    logic          r_zero;

    logic [VB:0]   rem2;
    logic          qbit;
    logic [VB-1:0] rem_nxt;

    always_comb begin
        rem2 = {r_rem, r_work[WB-1]};
        qbit = (rem2 >= {1'b0, r_den});
        rem_nxt = qbit ? VB'(rem2 - {1'b0, r_den}) : rem2[VB-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_work <= {sts_pkg::mag(i_num), 16'b0};
                r_rem  <= '0;
                r_den  <= sts_pkg::mag(i_den);
                r_neg  <= i_num[VB-1] ^ i_den[VB-1];
                r_zero <= (i_den == '0);
                r_cnt  <= 7'(WB);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= rem_nxt;
                r_work <= {r_work[WB-2:0], qbit};
                r_cnt  <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (r_zero) begin
            o_quot = '0;
        end else if (r_neg) begin
            if (r_work[WB-1:VB] != '0 || (r_work[VB-1] && r_work[VB-2:0] != '0)) begin
                o_quot = sts_pkg::VMIN;
            end else begin
                o_quot = -$signed(r_work[VB-1:0]);
            end
        end else begin
            if (r_work[WB-1:VB-1] != '0) begin
                o_quot = sts_pkg::VMAX;
            end else begin
                o_quot = $signed(r_work[VB-1:0]);
            end
        end
    end

    assign o_done = r_done;

endmodule

### rtl/core/sts_mul.sv
// Multi-cycle Q32.16 multiplier: 16 bits of one operand per cycle.
module sts_mul (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  sts_pkg::t_value i_a,
    input  sts_pkg::t_value i_b,
    output logic            o_done,
    output sts_pkg::t_value o_prod
);

    localparam int VB = sts_pkg::VALUE_BITS;
    localparam int PB = 2 * VB;
    localparam int NSTEP = VB / 16;

    logic [VB-1:0] r_a;
    logic [VB-1:0] r_b;
    logic [PB-1:0] r_acc;
    logic          r_neg;
    logic          r_busy;
    logic          r_done;
    logic [2:0]    r_k;

    logic [VB+15:0]  part;
    logic [PB-17:0]  p;

    assign part = (VB+16)'(r_a) * (VB+16)'(r_b[VB-1:VB-16]);
    assign p    = r_acc[PB-1:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= sts_pkg::mag(i_a);
                r_b    <= sts_pkg::mag(i_b);
                r_neg  <= i_a[VB-1] ^ i_b[VB-1];
                r_acc  <= '0;
                r_k    <= 3'(NSTEP);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= (r_acc << 16) + PB'(part);
                r_b   <= r_b << 16;
                r_k   <= r_k - 3'd1;
                if (r_k == 3'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (r_neg) begin
            if (p[PB-17:VB] != '0 || (p[VB-1] && p[VB-2:0] != '0)) begin
                o_prod = sts_pkg::VMIN;
            end else begin
                o_prod = -$signed(p[VB-1:0]);
            end
        end else begin
            if (p[PB-17:VB-1] != '0) begin
                o_prod = sts_pkg::VMAX;
            end else begin
                o_prod = $signed(p[VB-1:0]);
            end
        end
    end

    assign o_done = r_done;

endmodule
